### rtl/hclbe_pkg.sv
package hclbe_pkg;

    // One received response byte and its restart mark
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } item_t;

    // One forwarded body byte or the header error word
    typedef struct packed {
        logic [7:0] body_byte;
        logic       is_last;
        logic       header_error;
    } result_t;

    // Stream phase
    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_BODY   = 3'b010,
        PH_DONE   = 3'b100
    } phase_t;

    // Content-Length field tracking
    typedef enum logic [3:0] {
        NUM_SEARCH = 4'b0001,
        NUM_SKIP   = 4'b0010,
        NUM_READ   = 4'b0100,
        NUM_DONE   = 4'b1000
    } num_phase_t;

    localparam logic [3:0] KEY_LAST   = 4'd13;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Characters of the keyword "Content-Length"
    function automatic logic [7:0] keyword_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h43; // C
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h4C; // L
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

### rtl/hclbe_parser.sv
module hclbe_parser #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  hclbe_pkg::item_t    item,
    output logic                res_valid,
    output hclbe_pkg::result_t  res
);

    hclbe_pkg::phase_t      phase_reg, phase_next, phase_cur;
    hclbe_pkg::num_phase_t  num_reg, num_next, num_cur;
    logic [3:0]             kmi_reg, kmi_next, kmi_cur;
    logic [1:0]             lcc_reg, lcc_next, lcc_cur;
    logic [LENGTH_BITS-1:0] len_reg, len_next, len_cur;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next, rem_cur;
    logic [LENGTH_BITS+3:0] len_wide;
    logic [LENGTH_BITS+3:0] len_prod;
    logic [LENGTH_BITS-1:0] len_sat;
    logic [7:0]             b;
    logic                   is_digit;

    assign b        = item.data_byte;
    assign is_digit = (b >= hclbe_pkg::CHAR_ZERO) && (b <= hclbe_pkg::CHAR_NINE);

    // Restart clears the parser before the byte is handled
    always_comb
    begin
        if (item.restart)
        begin
            phase_cur = hclbe_pkg::PH_HEADER;
            num_cur   = hclbe_pkg::NUM_SEARCH;
            kmi_cur   = '0;
            lcc_cur   = '0;
            len_cur   = '0;
            rem_cur   = '0;
        end
        else
        begin
            phase_cur = phase_reg;
            num_cur   = num_reg;
            kmi_cur   = kmi_reg;
            lcc_cur   = lcc_reg;
            len_cur   = len_reg;
            rem_cur   = rem_reg;
        end
    end

    // Length times ten plus digit, saturating at all ones
    assign len_wide = {4'b0000, len_cur};
    assign len_prod = (len_wide << 3) + (len_wide << 1)
                    + {{LENGTH_BITS{1'b0}}, b[3:0]};
    assign len_sat  = (len_prod[LENGTH_BITS+3:LENGTH_BITS] != 4'b0000)
                    ? {LENGTH_BITS{1'b1}} : len_prod[LENGTH_BITS-1:0];

    always_comb
    begin
        phase_next = phase_cur;
        num_next   = num_cur;
        kmi_next   = kmi_cur;
        lcc_next   = lcc_cur;
        len_next   = len_cur;
        rem_next   = rem_cur;
        res_valid  = 1'b0;
        res        = '0;

        case (phase_cur)
            hclbe_pkg::PH_HEADER:
            begin
                // Track the keyword and the number that follows it
                case (num_cur)
                    hclbe_pkg::NUM_SEARCH:
                    begin
                        if (b == hclbe_pkg::keyword_char(kmi_cur))
                        begin
                            if (kmi_cur == hclbe_pkg::KEY_LAST)
                            begin
                                kmi_next = '0;
                                num_next = hclbe_pkg::NUM_SKIP;
                            end
                            else
                            begin
                                kmi_next = kmi_cur + 4'd1;
                            end
                        end
                        else
                        begin
                            kmi_next = (b == hclbe_pkg::keyword_char(4'd0)) ? 4'd1 : 4'd0;
                        end
                    end
                    hclbe_pkg::NUM_SKIP:
                    begin
                        if (b == hclbe_pkg::CHAR_LF)
                        begin
                            kmi_next = '0;
                            num_next = (len_cur == '0) ? hclbe_pkg::NUM_SEARCH
                                                       : hclbe_pkg::NUM_DONE;
                        end
                        else if (kmi_cur != 4'd0)
                        begin
                            kmi_next = '0;
                            num_next = hclbe_pkg::NUM_READ;
                        end
                        else
                        begin
                            kmi_next = 4'd1;
                        end
                    end
                    hclbe_pkg::NUM_READ:
                    begin
                        if (is_digit)
                        begin
                            len_next = len_sat;
                            kmi_next = 4'd1;
                        end
                        else if (!((b == hclbe_pkg::CHAR_SPACE) && (kmi_cur == 4'd0)))
                        begin
                            kmi_next = '0;
                            num_next = (len_cur == '0) ? hclbe_pkg::NUM_SEARCH
                                                       : hclbe_pkg::NUM_DONE;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                // Count line characters; one character plus LF ends the header
                if (b == hclbe_pkg::CHAR_LF)
                begin
                    lcc_next = '0;
                    if (lcc_cur == 2'd1)
                    begin
                        if (len_next == '0)
                        begin
                            phase_next       = hclbe_pkg::PH_DONE;
                            res_valid        = 1'b1;
                            res.header_error = 1'b1;
                        end
                        else
                        begin
                            phase_next = hclbe_pkg::PH_BODY;
                            rem_next   = len_next;
                        end
                    end
                end
                else if (lcc_cur != 2'd2)
                begin
                    lcc_next = lcc_cur + 2'd1;
                end
            end
            hclbe_pkg::PH_BODY:
            begin
                // Forward body bytes until the declared length is used up
                if (rem_cur != '0)
                begin
                    res_valid     = 1'b1;
                    res.body_byte = b;
                    res.is_last   = (rem_cur == {{(LENGTH_BITS-1){1'b0}}, 1'b1});
                    rem_next      = rem_cur - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
                    if (res.is_last)
                    begin
                        phase_next = hclbe_pkg::PH_DONE;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Advance parser state on each processed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hclbe_pkg::PH_HEADER;
            num_reg   <= hclbe_pkg::NUM_SEARCH;
            kmi_reg   <= '0;
            lcc_reg   <= '0;
            len_reg   <= '0;
            rem_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            num_reg   <= num_next;
            kmi_reg   <= kmi_next;
            lcc_reg   <= lcc_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

### rtl/http_content_length_body_extractor_core.sv
// Byte-serial HTTP response body extractor. Each input word carries one response byte;
// a restart mark on the first byte of a response clears the parser. The header is scanned
// for the case-sensitive Content-Length field, and once a line of one character plus LF
// ends the header, exactly that many body bytes are forwarded with the last one marked;
// a missing or zero length yields a single header_error word instead. Everything after
// is dropped until the next restart. The block takes one byte per clock cycle when the
// output is not stalled; a byte is held in the input register, and the parse stage
// loads its result into the result register whenever that register can take it.
// LENGTH_BITS sets the width of the declared length counter.
module http_content_length_body_extractor_core #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  hclbe_pkg::item_t    item,
    output logic                result_valid,
    input  logic                result_stall,
    output hclbe_pkg::result_t  result
);

    logic               s1_valid_reg;
    hclbe_pkg::item_t   s1_item_reg;
    logic               result_valid_reg;
    hclbe_pkg::result_t result_reg;
    logic               res_ready;
    logic               step;
    logic               res_valid;
    hclbe_pkg::result_t res;

    // The result register can load when empty or being drained
    assign res_ready  = !result_valid_reg || !result_stall;
    assign step       = s1_valid_reg && res_ready;
    assign item_stall = s1_valid_reg && !res_ready;

    // Hold the input word until the parse stage takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            s1_item_reg <= item;
        end
    end

    hclbe_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (s1_item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Load the result word, or drop it when the byte gives none
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            result_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### test/http_content_length_body_extractor_core_test.sv
`timescale 1ns / 100ps

module http_content_length_body_extractor_core_test;

    localparam int          LEN_BITS    = 32;
    localparam int unsigned ITEM_TARGET = 1350;
    localparam int unsigned DRAIN_LIMIT = 5000;
    localparam logic [LEN_BITS-1:0] LEN_MAX    = '1;
    localparam logic [8*14-1:0]     FIELD_NAME = "Content-Length";

    typedef enum int {
        STALL_OFF,
        STALL_SPARSE,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_mode_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    hclbe_pkg::item_t   item;
    logic               result_valid;
    logic               result_stall;
    hclbe_pkg::result_t result;

    // Expected output words, oldest first
    hclbe_pkg::result_t pending_body[$];
    int unsigned err_count   = 0;
    int unsigned items_sent  = 0;

    // Sender and receiver idling controls
    int unsigned gap_max     = 0;
    int unsigned burst_max   = 1;
    int unsigned burst_left  = 0;
    stall_mode_t stall_mode  = STALL_OFF;
    int unsigned stall_tick  = 0;

    // Parser state mirror
    hclbe_pkg::phase_t     prs_phase;
    hclbe_pkg::num_phase_t len_phase;
    logic [3:0]            match_idx;
    logic [LEN_BITS-1:0]   decl_len;
    logic [LEN_BITS-1:0]   body_left;
    logic [1:0]            line_chars;

    http_content_length_body_extractor_core #(
        .LENGTH_BITS(LEN_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Stall the output on the selected pattern
    always @(negedge clk)
    begin
        stall_tick <= stall_tick + 1;
        case (stall_mode)
            STALL_OFF:      result_stall <= 1'b0;
            STALL_SPARSE:   result_stall <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: result_stall <= ((stall_tick % 11) < 4);
            default:        result_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Compare each accepted output word with the oldest expectation
    always @(posedge clk)
    begin
        hclbe_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_body.size() == 0)
            begin
                $error("unexpected word: body_byte %02h is_last %0b header_error %0b",
                       result.body_byte, result.is_last, result.header_error);
                err_count++;
            end
            else
            begin
                want = pending_body.pop_front();
                if (result.body_byte !== want.body_byte)
                begin
                    $error("body_byte: expected %02h, got %02h",
                           want.body_byte, result.body_byte);
                    err_count++;
                end
                if (result.is_last !== want.is_last)
                begin
                    $error("is_last: expected %0b, got %0b", want.is_last, result.is_last);
                    err_count++;
                end
                if (result.header_error !== want.header_error)
                begin
                    $error("header_error: expected %0b, got %0b",
                           want.header_error, result.header_error);
                    err_count++;
                end
            end
        end
    end

    function automatic logic [7:0] field_char(input logic [3:0] idx);
        return FIELD_NAME[8*(13-idx) +: 8];
    endfunction

    task automatic clear_parser();
        prs_phase  = hclbe_pkg::PH_HEADER;
        len_phase  = hclbe_pkg::NUM_SEARCH;
        match_idx  = '0;
        decl_len   = '0;
        line_chars = '0;
        body_left  = '0;
    endtask

    // End the length field; a zero value reopens the keyword search
    task automatic close_length();
        match_idx = '0;
        len_phase = (decl_len == '0) ? hclbe_pkg::NUM_SEARCH : hclbe_pkg::NUM_DONE;
    endtask

    // Advance the parser mirror by one byte and queue any output word
    task automatic parse_response_byte(input hclbe_pkg::item_t w);
        logic [7:0]          b;
        logic [LEN_BITS-1:0] digit;
        logic                header_end;
        hclbe_pkg::result_t  want;
        b = w.data_byte;
        if (w.restart)
            clear_parser();
        if (prs_phase == hclbe_pkg::PH_HEADER)
        begin
            case (len_phase)
                hclbe_pkg::NUM_SEARCH:
                begin
                    if (b == field_char(match_idx))
                    begin
                        if (match_idx == hclbe_pkg::KEY_LAST)
                        begin
                            match_idx = '0;
                            len_phase = hclbe_pkg::NUM_SKIP;
                        end
                        else
                            match_idx++;
                    end
                    else
                        match_idx = (b == field_char(4'd0)) ? 4'd1 : 4'd0;
                end
                hclbe_pkg::NUM_SKIP:
                begin
                    if (b == hclbe_pkg::CHAR_LF)
                        close_length();
                    else if (match_idx == 4'd1)
                    begin
                        match_idx = '0;
                        len_phase = hclbe_pkg::NUM_READ;
                    end
                    else
                        match_idx++;
                end
                hclbe_pkg::NUM_READ:
                begin
                    if (b >= hclbe_pkg::CHAR_ZERO && b <= hclbe_pkg::CHAR_NINE)
                    begin
                        digit = LEN_BITS'(b - hclbe_pkg::CHAR_ZERO);
                        if (decl_len > (LEN_MAX - digit) / 10)
                            decl_len = LEN_MAX;
                        else
                            decl_len = decl_len * 10 + digit;
                        match_idx = 4'd1;
                    end
                    else if (!(b == hclbe_pkg::CHAR_SPACE && match_idx == 4'd0))
                        close_length();
                end
                default: ;
            endcase
            // Track line length; one character plus LF ends the header
            if (b == hclbe_pkg::CHAR_LF)
            begin
                header_end = (line_chars == 2'd1);
                line_chars = '0;
                if (header_end)
                begin
                    if (decl_len == '0)
                    begin
                        prs_phase = hclbe_pkg::PH_DONE;
                        want.body_byte    = 8'h00;
                        want.is_last      = 1'b0;
                        want.header_error = 1'b1;
                        pending_body.push_back(want);
                    end
                    else
                    begin
                        prs_phase = hclbe_pkg::PH_BODY;
                        body_left = decl_len;
                    end
                end
            end
            else if (line_chars < 2'd2)
                line_chars++;
        end
        else if (prs_phase == hclbe_pkg::PH_BODY && body_left != '0)
        begin
            want.body_byte    = b;
            want.is_last      = (body_left == 1);
            want.header_error = 1'b0;
            pending_body.push_back(want);
            body_left--;
            if (body_left == '0)
                prs_phase = hclbe_pkg::PH_DONE;
        end
    endtask

    // Send one word, with a random gap at the start of each burst
    task automatic send_word(input logic [7:0] b, input logic rs);
        hclbe_pkg::item_t w;
        int unsigned      gap;
        w.data_byte = b;
        w.restart   = rs;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, burst_max);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0)
            begin
                item_valid = 1'b0;
                item       = hclbe_pkg::item_t'(9'($urandom));
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        item       = w;
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        items_sent++;
        parse_response_byte(w);
    endtask

    task automatic send_text(input string s, input logic fresh);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], fresh && (i == 0));
    endtask

    task automatic set_idling(input int unsigned gap, input int unsigned burst,
                              input stall_mode_t mode);
        gap_max    = gap;
        burst_max  = burst;
        stall_mode = mode;
        burst_left = 0;
    endtask

    // Hold the sender until every expected word has come out
    task automatic wait_drained();
        int unsigned n;
        n = 0;
        @(negedge clk);
        item_valid = 1'b0;
        while (pending_body.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        if (pending_body.size() != 0)
        begin
            $error("%0d expected words never arrived", pending_body.size());
            err_count++;
            pending_body.delete();
        end
    endtask

    function automatic string filler_line();
        string       ln;
        int unsigned n;
        if ($urandom_range(0, 3) == 0)
            ln = "Content-";
        else
            ln = "";
        n = $urandom_range(1, 8);
        repeat (n) ln = $sformatf("%s%c", ln, $urandom_range(32, 126));
        return {ln, "\r\n"};
    endfunction

    // Well-formed response with random content; optionally cut inside the body
    task automatic send_response(input logic cut_body);
        string       hdr;
        string       sep;
        int unsigned blen;
        int unsigned sent;
        if ($urandom_range(0, 1) != 0)
            hdr = "HTTP/1.1 200 OK\r\n";
        else
            hdr = "";
        repeat ($urandom_range(0, 2)) hdr = {hdr, filler_line()};
        blen = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        if ($urandom_range(0, 2) != 0)
            sep = ": ";
        else
            sep = $sformatf("%c%c", $urandom_range(33, 126), $urandom_range(33, 126));
        repeat ($urandom_range(0, 3)) sep = {sep, " "};
        hdr = {hdr, "Content-Length", sep, $sformatf("%0d\r\n", blen)};
        repeat ($urandom_range(0, 2)) hdr = {hdr, filler_line()};
        if ($urandom_range(0, 3) != 0)
            hdr = {hdr, "\r\n"};
        else
            hdr = $sformatf("%s%c\n", hdr, $urandom_range(33, 126));
        send_text(hdr, 1'b1);
        sent = cut_body ? blen / 2 : blen + $urandom_range(0, 3);
        repeat (sent) send_word(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic test_byte_extremes();
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b0);
        wait_drained();
    endtask

    task automatic test_basic_body();
        send_text("Content-Length: 3\r\n\r\nabcXYZ", 1'b1);
        wait_drained();
    endtask

    task automatic test_empty_line();
        // bare LF lines keep the header open; "Q\n" closes it
        send_text("\n\nContent-Length: 2\r\n\nQ\nhi!", 1'b1);
        wait_drained();
    endtask

    task automatic test_length_spacing();
        send_text("Content-Length:    5\r\n\r\n12345", 1'b1);
        // no space: the skip eats the digit, the CR ends a zero number
        send_text("Content-Length:7\r\nX\nzz", 1'b1);
        wait_drained();
    endtask

    task automatic test_keyword_mismatch();
        send_text("CContent-Length: 2\r\nA\nhiho", 1'b1);
        send_text("Content-Lengt: 4\r\nContent Length: 4\r\n\r\nab", 1'b1);
        wait_drained();
    endtask

    task automatic test_zero_and_missing();
        send_text("Content-Length: 0\r\n\r\nzz", 1'b1);
        send_text("Content-Length: -5\r\n\r\n", 1'b1);
        send_text("Date: x\r\n\r\nq", 1'b1);
        send_text("Content-Length: 0\r\nContent-Length: 2\r\n\r\nokNO", 1'b1);
        wait_drained();
    endtask

    task automatic test_line_feed_cut();
        send_text("Content-Len\ngth: 2\r\n\r\n", 1'b1);
        send_text("Content-Length\n: 3\r\n\r\n", 1'b1);
        send_text("Content-Length: 1\n2\r\n\r\nab", 1'b1);
        wait_drained();
    endtask

    task automatic test_later_length_ignored();
        send_text("Content-Length: 2\r\nContent-Length: 9\r\n\r\nxyz", 1'b1);
        wait_drained();
    endtask

    task automatic test_saturation();
        send_text("Content-Length: 99999999999\r\n\r\n", 1'b1);
        repeat (6) send_word(8'($urandom_range(0, 255)), 1'b0);
        send_text("Content-Length: 4294967295\r\n\r\nab", 1'b1);
        wait_drained();
    endtask

    task automatic test_restart_midway();
        send_text("Content-Length: 8\r\n\r\nabc", 1'b1);
        send_text("Content-Len", 1'b1);
        send_text("Content-Length: 1\r\n\r\nQR", 1'b1);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int unsigned responses;
        string       bad;
        responses = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (responses % 5 == 0)
                set_idling(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8),
                           $urandom_range(1, 16), stall_mode_t'($urandom_range(0, 3)));
            case ($urandom_range(0, 9))
                0:
                begin
                    // noise, with stray restarts
                    for (int i = 0; i < int'($urandom_range(1, 12)); i++)
                        send_word(8'($urandom_range(0, 255)),
                                  (i == 0) || ($urandom_range(0, 5) == 0));
                end
                1, 2:
                begin
                    // broken length fields
                    case ($urandom_range(0, 5))
                        0: bad = "Content-Le\nngth: 5\r\n";
                        1: bad = "Content-Length: 0\r\n";
                        2: bad = $sformatf("Content-Length: -%0d\r\n", $urandom_range(1, 9));
                        3: bad = $sformatf("Content-Length: %0d\n%0d\r\n",
                                           $urandom_range(1, 9), $urandom_range(0, 9));
                        4: bad = $sformatf("Content-Length:%0d\r\n", $urandom_range(10, 999));
                        default: bad = $sformatf("Content-Length: %0d000000000\r\n",
                                                 $urandom_range(5, 99));
                    endcase
                    if ($urandom_range(0, 2) == 0)
                        bad = {bad, $sformatf("Content-Length: %0d\r\n", $urandom_range(1, 8))};
                    send_text({bad, "\r\n"}, 1'b1);
                    repeat ($urandom_range(0, 12)) send_word(8'($urandom_range(0, 255)), 1'b0);
                end
                3:       send_response(1'b1);
                default: send_response(1'b0);
            endcase
            responses++;
            if (responses % 9 == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_stall = 1'b0;
        clear_parser();
        set_idling(0, 1, STALL_OFF);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_byte_extremes();
        test_basic_body();
        test_empty_line();
        set_idling(3, 4, STALL_PERIODIC);
        test_length_spacing();
        test_keyword_mismatch();
        test_zero_and_missing();
        set_idling(1, 2, STALL_SPARSE);
        test_line_feed_cut();
        test_later_length_ignored();
        set_idling(6, 8, STALL_HEAVY);
        test_saturation();
        test_restart_midway();
        test_random_traffic();

        wait_drained();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
